// ----- rtl/brf_pkg.sv -----
`timescale 1ns / 1ps

package brf_pkg;

  localparam int DEF_MAX_DEPTH = 1024;
  localparam int LG_MAX        = 10;

  localparam int CNT_W      = 32;
  localparam int FILL_W     = 11;
  localparam int OFF_W      = 10;
  localparam int BYTE_W     = 8;
  localparam int LG_W       = 4;
  localparam int CMD_W      = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH            = 3'd0,
    CMD_POP             = 3'd1,
    CMD_COMMIT_PRODUCED = 3'd2,
    CMD_COMMIT_CONSUMED = 3'd3,
    CMD_PUBLISH         = 3'd4,
    CMD_CLEAR           = 3'd5
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RING_SIZE_LOG2 = 1'b0,
    REG_KEEP_NEWEST    = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic              ok;
    logic [BYTE_W-1:0] read_byte;
    logic [FILL_W-1:0] occupancy;
    logic [FILL_W-1:0] vacancy;
    logic [OFF_W-1:0]  read_offset;
    logic [FILL_W-1:0] read_length;
    logic [OFF_W-1:0]  write_offset;
    logic [FILL_W-1:0] write_length;
    logic [FILL_W-1:0] peak_fill;
    logic [CNT_W-1:0]  lost_bytes;
    logic [CNT_W-1:0]  producer_position;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [OFF_W-1:0]  waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [OFF_W-1:0]  raddr;
  } store_req_t;

  // largest usable ring log2 for a given store depth
  function automatic int max_lg(input int depth);
    int fl;
    fl = $clog2(depth + 1) - 1;
    return (fl > LG_MAX) ? LG_MAX : fl;
  endfunction

endpackage

// ----- rtl/byte_ring_fifo_with_watermark.sv -----
`timescale 1ns / 1ps

// Byte ring FIFO with free-running 32-bit producer and consumer counters, a fill
// watermark and a wrapping overflow tally. Each input transaction runs one command
// (push, pop, commit produced, commit consumed, publish producer, clear) and returns
// one result with the ring status after it. The byte store is a synchronous RAM of
// 2^min(10, floor(log2 MAX_DEPTH)) bytes; its contents are undefined until pushed and
// it needs no clearing pass. The accept cycle issues the store read at the consumer
// position; the execute state then runs the command, writes the store back and
// loads the output register. A new transaction is taken only after the previous one
// has executed and the block is back in idle, so transactions do not overlap; a
// result not yet taken holds the execute state. Configuration is accepted while no
// transaction is in flight and goes ahead of a waiting input transaction; writing
// ring_size_log2 zeroes the producer, consumer and watermark.
module byte_ring_fifo_with_watermark
  import brf_pkg::*;
#(
  parameter int MAX_DEPTH = DEF_MAX_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CMD_W-1:0]      cmd,
  input  logic [BYTE_W-1:0]     data_byte,
  input  logic [FILL_W-1:0]     count,
  input  logic [CNT_W-1:0]      new_producer,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  ok,
  output logic [BYTE_W-1:0]     read_byte,
  output logic [FILL_W-1:0]     occupancy,
  output logic [FILL_W-1:0]     vacancy,
  output logic [OFF_W-1:0]      read_offset,
  output logic [FILL_W-1:0]     read_length,
  output logic [OFF_W-1:0]      write_offset,
  output logic [FILL_W-1:0]     write_length,
  output logic [FILL_W-1:0]     peak_fill,
  output logic [CNT_W-1:0]      lost_bytes,
  output logic [CNT_W-1:0]      producer_position,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  state_t            state;
  state_t            state_next;
  logic              accept;
  logic              fire;
  logic              cfg_we;
  logic              out_valid_next;
  store_req_t        req;
  result_t           result;
  result_t           res_q;
  logic [BYTE_W-1:0] rd_data;

  brf_store #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  brf_core #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .fire         (fire),
    .cmd          (cmd),
    .data_byte    (data_byte),
    .count        (count),
    .new_producer (new_producer),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .rd_data      (rd_data),
    .req          (req),
    .result       (result)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    cfg_ready = 1'b0;
    fire      = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready  = !rst && !cfg_valid;
        cfg_ready = !rst;
      end
      S_EXEC: begin
        fire = !out_valid || out_ready;
      end
    endcase
  end

  assign accept = in_valid && in_ready;
  assign cfg_we = cfg_valid && cfg_ready;

  always_comb begin
    priority if (fire) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= result;
    end
  end

  assign ok                = res_q.ok;
  assign read_byte         = res_q.read_byte;
  assign occupancy         = res_q.occupancy;
  assign vacancy           = res_q.vacancy;
  assign read_offset       = res_q.read_offset;
  assign read_length       = res_q.read_length;
  assign write_offset      = res_q.write_offset;
  assign write_length      = res_q.write_length;
  assign peak_fill         = res_q.peak_fill;
  assign lost_bytes        = res_q.lost_bytes;
  assign producer_position = res_q.producer_position;

  // read and write-back of the store never overlap
  a_store_interlock: assert property (@(posedge clk) disable iff (rst)
    !(req.we && req.re))
    else $error("store read and write in the same cycle");

  // a retiring transaction always presents its result
  a_fire_loads: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("result lost at retire");

  // configuration never lands on a transaction in flight
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_we |-> (state == S_IDLE) && !fire)
    else $error("configuration write during a transaction");

endmodule

// ----- rtl/brf_store.sv -----
`timescale 1ns / 1ps

module brf_store
  import brf_pkg::*;
#(
  parameter int MAX_DEPTH = DEF_MAX_DEPTH
) (
  input  logic              clk,
  input  store_req_t        req,
  output logic [BYTE_W-1:0] rd_data
);

  localparam int MAX_LG = max_lg(MAX_DEPTH);
  localparam int DEPTH  = 1 << MAX_LG;
  localparam int AW     = (MAX_LG > 0) ? MAX_LG : 1;

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data <= mem[req.raddr[AW-1:0]];
    end
  end

endmodule

// ----- rtl/brf_core.sv -----
`timescale 1ns / 1ps

module brf_core
  import brf_pkg::*;
#(
  parameter int MAX_DEPTH = DEF_MAX_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic                  fire,
  input  logic [CMD_W-1:0]      cmd,
  input  logic [BYTE_W-1:0]     data_byte,
  input  logic [FILL_W-1:0]     count,
  input  logic [CNT_W-1:0]      new_producer,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [BYTE_W-1:0]     rd_data,
  output store_req_t            req,
  output result_t               result
);

  localparam int MAX_LG = max_lg(MAX_DEPTH);

  logic [LG_W-1:0]   ring_lg;
  logic              keep_newest;
  logic [CNT_W-1:0]  head;
  logic [CNT_W-1:0]  tail;
  logic [FILL_W-1:0] peak;
  logic [CNT_W-1:0]  overflow;

  logic [CNT_W-1:0]  head_next;
  logic [CNT_W-1:0]  tail_next;
  logic [FILL_W-1:0] peak_next;
  logic [CNT_W-1:0]  overflow_next;

  logic [CMD_W-1:0]  cmd_q;
  logic [BYTE_W-1:0] data_q;
  logic [FILL_W-1:0] count_q;
  logic [CNT_W-1:0]  delta_q;
  logic [CNT_W-1:0]  lost_q;

  logic [LG_W-1:0]   lg_eff;
  logic [FILL_W-1:0] size;
  logic [OFF_W-1:0]  mask;
  logic [FILL_W-1:0] occ;
  logic [FILL_W-1:0] room;

  logic              ok;
  logic [BYTE_W-1:0] rbyte;
  logic              we;
  logic              pin_peak;
  logic              zero_peak;

  logic [FILL_W-1:0] occ_n;
  logic [FILL_W-1:0] room_n;
  logic [OFF_W-1:0]  roff_n;
  logic [OFF_W-1:0]  woff_n;
  logic [FILL_W-1:0] rspan;
  logic [FILL_W-1:0] wspan;
  logic [FILL_W-1:0] rlen_n;
  logic [FILL_W-1:0] wlen_n;

  // ring geometry
  assign lg_eff = (ring_lg > LG_W'(MAX_LG)) ? LG_W'(MAX_LG) : ring_lg;
  assign size   = FILL_W'(1) << lg_eff;
  assign mask   = OFF_W'(size - FILL_W'(1));
  assign occ    = head[FILL_W-1:0] - tail[FILL_W-1:0];
  assign room   = size - occ;

  // transaction capture and publish distance, worked out at accept
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= cmd;
      data_q  <= data_byte;
      count_q <= count;
      delta_q <= new_producer - head;
      lost_q  <= new_producer - head - CNT_W'(room);
    end
  end

  always_comb begin
    head_next     = head;
    tail_next     = tail;
    overflow_next = overflow;
    ok            = 1'b0;
    rbyte         = '0;
    we            = 1'b0;
    pin_peak      = 1'b0;
    zero_peak     = 1'b0;
    unique case (cmd_q)
      CMD_PUSH: begin
        if (room != '0) begin
          we        = 1'b1;
          head_next = head + CNT_W'(1);
          ok        = 1'b1;
        end else begin
          overflow_next = overflow + CNT_W'(1);
        end
      end
      CMD_POP: begin
        if (occ != '0) begin
          rbyte     = rd_data;
          tail_next = tail + CNT_W'(1);
          ok        = 1'b1;
        end
      end
      CMD_COMMIT_PRODUCED: begin
        if (count_q <= room) begin
          head_next = head + CNT_W'(count_q);
          ok        = 1'b1;
        end
      end
      CMD_COMMIT_CONSUMED: begin
        if (count_q <= occ) begin
          tail_next = tail + CNT_W'(count_q);
          ok        = 1'b1;
        end
      end
      CMD_PUBLISH: begin
        if (delta_q == '0 || delta_q[CNT_W-1]) begin
          ok = 1'b1;
        end else if (lost_q[CNT_W-1] || lost_q == '0) begin
          head_next = head + delta_q;
          ok        = 1'b1;
        end else begin
          overflow_next = overflow + lost_q;
          pin_peak      = 1'b1;
          if (keep_newest) begin
            tail_next = tail + lost_q;
            head_next = head + delta_q;
          end else begin
            head_next = head + CNT_W'(room);
          end
        end
      end
      CMD_CLEAR: begin
        head_next     = '0;
        tail_next     = '0;
        overflow_next = '0;
        zero_peak     = 1'b1;
        ok            = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // status after the transaction
  assign occ_n  = head_next[FILL_W-1:0] - tail_next[FILL_W-1:0];
  assign room_n = size - occ_n;
  assign roff_n = tail_next[OFF_W-1:0] & mask;
  assign woff_n = head_next[OFF_W-1:0] & mask;
  assign rspan  = size - FILL_W'(roff_n);
  assign wspan  = size - FILL_W'(woff_n);
  assign rlen_n = (occ_n == '0) ? '0 : ((occ_n < rspan) ? occ_n : rspan);
  assign wlen_n = (room_n == '0) ? '0 : ((room_n < wspan) ? room_n : wspan);

  always_comb begin
    priority if (zero_peak) begin
      peak_next = '0;
    end else if (pin_peak) begin
      peak_next = size;
    end else if (occ_n > peak) begin
      peak_next = occ_n;
    end else begin
      peak_next = peak;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_lg     <= LG_W'(LG_MAX);
      keep_newest <= 1'b0;
      head        <= '0;
      tail        <= '0;
      peak        <= '0;
      overflow    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_RING_SIZE_LOG2: begin
          ring_lg <= cfg_data[LG_W-1:0];
          head    <= '0;
          tail    <= '0;
          peak    <= '0;
        end
        REG_KEEP_NEWEST: begin
          keep_newest <= cfg_data[0];
        end
      endcase
    end else if (fire) begin
      head     <= head_next;
      tail     <= tail_next;
      peak     <= peak_next;
      overflow <= overflow_next;
    end
  end

  // store access: read at accept, write back when the transaction retires
  assign req.we    = fire && we;
  assign req.waddr = head[OFF_W-1:0] & mask;
  assign req.wdata = data_q;
  assign req.re    = accept;
  assign req.raddr = tail[OFF_W-1:0] & mask;

  assign result.ok                = ok;
  assign result.read_byte         = rbyte;
  assign result.occupancy         = occ_n;
  assign result.vacancy           = room_n;
  assign result.read_offset       = roff_n;
  assign result.read_length       = rlen_n;
  assign result.write_offset      = woff_n;
  assign result.write_length      = wlen_n;
  assign result.peak_fill         = peak_next;
  assign result.lost_bytes        = overflow_next;
  assign result.producer_position = head_next;

  // fill never runs past the ring
  a_occ_in_ring: assert property (@(posedge clk) disable iff (rst)
    (head - tail) <= CNT_W'(size))
    else $error("occupancy beyond ring size");

  // the watermark covers the current fill
  a_peak_covers: assert property (@(posedge clk) disable iff (rst)
    peak >= occ)
    else $error("watermark below occupancy");

endmodule

// ----- verif/tb_byte_ring_fifo_with_watermark.sv -----
`timescale 1ns / 1ps

module tb_byte_ring_fifo_with_watermark;
  import brf_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 170;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    bit                is_cfg;
    bit                set_lg;
    logic [LG_W-1:0]   lg;
    logic [3:0]        keep;
    logic [CMD_W-1:0]  op;
    logic [BYTE_W-1:0] b;
    logic [FILL_W-1:0] n;
    logic [CNT_W-1:0]  np;
    bit                typed;
    logic              t_ok;
    logic [BYTE_W-1:0] t_byte;
    logic [FILL_W-1:0] t_occ;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [CMD_W-1:0]      cmd = '0;
  logic [BYTE_W-1:0]     data_byte = '0;
  logic [FILL_W-1:0]     count = '0;
  logic [CNT_W-1:0]      new_producer = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  ok;
  logic [BYTE_W-1:0]     read_byte;
  logic [FILL_W-1:0]     occupancy;
  logic [FILL_W-1:0]     vacancy;
  logic [OFF_W-1:0]      read_offset;
  logic [FILL_W-1:0]     read_length;
  logic [OFF_W-1:0]      write_offset;
  logic [FILL_W-1:0]     write_length;
  logic [FILL_W-1:0]     peak_fill;
  logic [CNT_W-1:0]      lost_bytes;
  logic [CNT_W-1:0]      producer_position;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // ring mirror
  logic [CNT_W-1:0]  prod_pos;
  logic [CNT_W-1:0]  cons_pos;
  logic [FILL_W-1:0] peak_mark;
  logic [CNT_W-1:0]  spill_total;
  logic [LG_W-1:0]   lg_setting;
  logic              drop_oldest;
  logic [BYTE_W-1:0] shadow [DEF_MAX_DEPTH];
  logic [DEF_MAX_DEPTH-1:0] filled;

  result_t status_due [$];
  row_t    plan [$];

  bit calm = 1'b0;
  int hold_asks = 0;
  int mismatches = 0;
  int items_sent = 0;
  int statuses_checked = 0;
  int cfg_writes = 0;
  int full_pushes = 0;
  int spill_publishes = 0;

  byte_ring_fifo_with_watermark uut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .cmd               (cmd),
    .data_byte         (data_byte),
    .count             (count),
    .new_producer      (new_producer),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .ok                (ok),
    .read_byte         (read_byte),
    .occupancy         (occupancy),
    .vacancy           (vacancy),
    .read_offset       (read_offset),
    .read_length       (read_length),
    .write_offset      (write_offset),
    .write_length      (write_length),
    .peak_fill         (peak_fill),
    .lost_bytes        (lost_bytes),
    .producer_position (producer_position),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #4 clk = ~clk;

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", status_due.size());
    $display("FAILURE");
    $finish;
  end

  task automatic flag_mismatch(input string what, input logic [CNT_W-1:0] got,
                               input logic [CNT_W-1:0] want);
    $display("mismatch at result %0d: %s got 0x%0h want 0x%0h",
             statuses_checked, what, got, want);
    mismatches++;
  endtask

  function automatic logic [CNT_W-1:0] ring_bytes();
    logic [LG_W-1:0] lg;
    lg = (lg_setting > LG_MAX) ? LG_W'(LG_MAX) : lg_setting;
    return 32'd1 << lg;
  endfunction

  // runs one command on the mirror and returns the status it should report
  function automatic result_t advance_ring(input logic [CMD_W-1:0] op,
                                           input logic [BYTE_W-1:0] b,
                                           input logic [FILL_W-1:0] n,
                                           input logic [CNT_W-1:0] np);
    logic [CNT_W-1:0] size, occ, room, delta, spill, span, roff, woff;
    result_t r;
    size = ring_bytes();
    occ = prod_pos - cons_pos;
    room = (occ >= size) ? 32'd0 : size - occ;
    r = '0;
    case (op)
      CMD_PUSH: begin
        if (room == 0) begin
          spill_total = spill_total + 1;
          full_pushes++;
        end else begin
          shadow[prod_pos & (size - 1)] = b;
          filled[prod_pos & (size - 1)] = 1'b1;
          prod_pos = prod_pos + 1;
          r.ok = 1'b1;
        end
      end
      CMD_POP: begin
        if (occ != 0) begin
          r.read_byte = shadow[cons_pos & (size - 1)];
          cons_pos = cons_pos + 1;
          r.ok = 1'b1;
        end
      end
      CMD_COMMIT_PRODUCED: begin
        if (n <= room) begin
          prod_pos = prod_pos + n;
          r.ok = 1'b1;
        end
      end
      CMD_COMMIT_CONSUMED: begin
        if (n <= occ) begin
          cons_pos = cons_pos + n;
          r.ok = 1'b1;
        end
      end
      CMD_PUBLISH: begin
        delta = np - prod_pos;
        if (delta == 0 || delta[31]) begin
          r.ok = 1'b1;
        end else if (delta <= room) begin
          prod_pos = np;
          r.ok = 1'b1;
        end else begin
          spill = delta - room;
          spill_total = spill_total + spill;
          if (drop_oldest) begin
            cons_pos = cons_pos + spill;
            prod_pos = np;
          end else begin
            prod_pos = prod_pos + room;
          end
          peak_mark = size[FILL_W-1:0];
          spill_publishes++;
        end
      end
      CMD_CLEAR: begin
        prod_pos = '0;
        cons_pos = '0;
        peak_mark = '0;
        spill_total = '0;
        r.ok = 1'b1;
      end
      default: begin
      end
    endcase
    occ = prod_pos - cons_pos;
    room = (occ >= size) ? 32'd0 : size - occ;
    // occupancy only grows through push, commit produced and publish
    if (occ > peak_mark) peak_mark = occ[FILL_W-1:0];
    roff = cons_pos & (size - 1);
    woff = prod_pos & (size - 1);
    span = size - roff;
    r.read_length = (occ == 0) ? '0 : FILL_W'((occ < span) ? occ : span);
    span = size - woff;
    r.write_length = (room == 0) ? '0 : FILL_W'((room < span) ? room : span);
    r.occupancy = occ[FILL_W-1:0];
    r.vacancy = room[FILL_W-1:0];
    r.read_offset = roff[OFF_W-1:0];
    r.write_offset = woff[OFF_W-1:0];
    r.peak_fill = peak_mark;
    r.lost_bytes = spill_total;
    r.producer_position = prod_pos;
    return r;
  endfunction

  function automatic row_t cmd_row(input logic [CMD_W-1:0] op, input logic [BYTE_W-1:0] b,
                                   input logic [FILL_W-1:0] n, input logic [CNT_W-1:0] np);
    row_t r;
    r = '0;
    r.op = op;
    r.b = b;
    r.n = n;
    r.np = np;
    return r;
  endfunction

  function automatic row_t known_row(input logic [CMD_W-1:0] op, input logic [BYTE_W-1:0] b,
                                     input logic [FILL_W-1:0] n, input logic [CNT_W-1:0] np,
                                     input logic t_ok, input logic [BYTE_W-1:0] t_byte,
                                     input logic [FILL_W-1:0] t_occ);
    row_t r;
    r = cmd_row(op, b, n, np);
    r.typed = 1'b1;
    r.t_ok = t_ok;
    r.t_byte = t_byte;
    r.t_occ = t_occ;
    return r;
  endfunction

  function automatic row_t cfg_row(input bit set_lg, input logic [LG_W-1:0] lg,
                                   input logic [3:0] keep);
    row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.set_lg = set_lg;
    r.lg = lg;
    r.keep = keep;
    return r;
  endfunction

  task automatic run_item(input logic [CMD_W-1:0] op, input logic [BYTE_W-1:0] b,
                          input logic [FILL_W-1:0] n, input logic [CNT_W-1:0] np,
                          input bit typed, input logic t_ok, input logic [BYTE_W-1:0] t_byte,
                          input logic [FILL_W-1:0] t_occ);
    result_t want;
    want = advance_ring(op, b, n, np);
    if (typed) begin
      want.ok = t_ok;
      want.read_byte = t_byte;
      want.occupancy = t_occ;
    end
    while (!calm && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= op;
    data_byte <= b;
    count <= n;
    new_producer <= np;
    do @(posedge clk); while (!in_ready);
    status_due.push_back(want);
    items_sent++;
  endtask

  // only once all outstanding results have returned; a size write restarts the counters
  task automatic set_ring(input bit set_lg, input logic [LG_W-1:0] lg, input logic [3:0] keep);
    in_valid <= 1'b0;
    do @(posedge clk); while (status_due.size() != 0);
    if (set_lg) begin
      cfg_valid <= 1'b1;
      cfg_index <= REG_RING_SIZE_LOG2;
      cfg_data <= lg;
      do @(posedge clk); while (!cfg_ready);
      lg_setting = lg;
      prod_pos = '0;
      cons_pos = '0;
      peak_mark = '0;
      cfg_writes++;
    end
    cfg_valid <= 1'b1;
    cfg_index <= REG_KEEP_NEWEST;
    cfg_data <= keep;
    do @(posedge clk); while (!cfg_ready);
    drop_oldest = keep[0];
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  // result side
  initial begin
    int hold_left;
    int holds_done;
    result_t want;
    hold_left = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_ready) begin
        if (status_due.size() == 0) begin
          flag_mismatch("result with nothing outstanding", '0, '0);
        end else begin
          want = status_due.pop_front();
          if (ok !== want.ok) flag_mismatch("ok", CNT_W'(ok), CNT_W'(want.ok));
          if (read_byte !== want.read_byte)
            flag_mismatch("read_byte", CNT_W'(read_byte), CNT_W'(want.read_byte));
          if (occupancy !== want.occupancy)
            flag_mismatch("occupancy", CNT_W'(occupancy), CNT_W'(want.occupancy));
          if (vacancy !== want.vacancy)
            flag_mismatch("vacancy", CNT_W'(vacancy), CNT_W'(want.vacancy));
          if (read_offset !== want.read_offset)
            flag_mismatch("read_offset", CNT_W'(read_offset), CNT_W'(want.read_offset));
          if (read_length !== want.read_length)
            flag_mismatch("read_length", CNT_W'(read_length), CNT_W'(want.read_length));
          if (write_offset !== want.write_offset)
            flag_mismatch("write_offset", CNT_W'(write_offset), CNT_W'(want.write_offset));
          if (write_length !== want.write_length)
            flag_mismatch("write_length", CNT_W'(write_length), CNT_W'(want.write_length));
          if (peak_fill !== want.peak_fill)
            flag_mismatch("peak_fill", CNT_W'(peak_fill), CNT_W'(want.peak_fill));
          if (lost_bytes !== want.lost_bytes)
            flag_mismatch("lost_bytes", lost_bytes, want.lost_bytes);
          if (producer_position !== want.producer_position)
            flag_mismatch("producer_position", producer_position, want.producer_position);
        end
        statuses_checked++;
      end
      if (hold_asks != holds_done) begin
        holds_done = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || $urandom_range(99) >= 21;
      end
    end
  end

  // command side
  initial begin
    logic [CMD_W-1:0]  op;
    logic [BYTE_W-1:0] b;
    logic [FILL_W-1:0] n;
    logic [CNT_W-1:0]  np;
    logic [CNT_W-1:0]  sz;
    logic [CNT_W-1:0]  fill;
    logic [LG_W-1:0]   lg;
    int pick;
    int tilt;
    int wait_left;

    prod_pos = '0;
    cons_pos = '0;
    peak_mark = '0;
    spill_total = '0;
    lg_setting = LG_W'(LG_MAX);
    drop_oldest = 1'b0;
    filled = '0;

    plan.push_back(known_row(CMD_POP, 8'h00, 11'd0, 32'd0, 1'b0, 8'h00, 11'd0));
    plan.push_back(cfg_row(1'b1, 4'd2, 4'h0));
    plan.push_back(known_row(CMD_PUSH, 8'h00, 11'd0, 32'd0, 1'b1, 8'h00, 11'd1));
    plan.push_back(known_row(CMD_PUSH, 8'hFF, 11'd0, 32'd0, 1'b1, 8'h00, 11'd2));
    plan.push_back(known_row(CMD_PUSH, 8'hA5, 11'd0, 32'd0, 1'b1, 8'h00, 11'd3));
    plan.push_back(known_row(CMD_PUSH, 8'h5A, 11'd0, 32'd0, 1'b1, 8'h00, 11'd4));
    // full ring
    plan.push_back(known_row(CMD_PUSH, 8'h11, 11'd0, 32'd0, 1'b0, 8'h00, 11'd4));
    plan.push_back(known_row(CMD_COMMIT_PRODUCED, 8'h00, 11'd1, 32'd0, 1'b0, 8'h00, 11'd4));
    plan.push_back(known_row(CMD_COMMIT_PRODUCED, 8'h00, 11'd0, 32'd0, 1'b1, 8'h00, 11'd4));
    plan.push_back(known_row(CMD_POP, 8'h00, 11'd0, 32'd0, 1'b1, 8'h00, 11'd3));
    plan.push_back(known_row(CMD_COMMIT_CONSUMED, 8'h00, 11'd4, 32'd0, 1'b0, 8'h00, 11'd3));
    plan.push_back(known_row(CMD_COMMIT_CONSUMED, 8'h00, 11'd1, 32'd0, 1'b1, 8'h00, 11'd2));
    plan.push_back(known_row(CMD_POP, 8'h00, 11'd0, 32'd0, 1'b1, 8'hA5, 11'd1));
    // stale positions, then an exact fill, then clamping
    plan.push_back(known_row(CMD_PUBLISH, 8'h00, 11'd0, 32'd4, 1'b1, 8'h00, 11'd1));
    plan.push_back(known_row(CMD_PUBLISH, 8'h00, 11'd0, 32'hFFFF_FFFF, 1'b1, 8'h00, 11'd1));
    plan.push_back(known_row(CMD_PUBLISH, 8'h00, 11'd0, 32'd7, 1'b1, 8'h00, 11'd4));
    plan.push_back(known_row(CMD_PUBLISH, 8'h00, 11'd0, 32'd12, 1'b0, 8'h00, 11'd4));
    plan.push_back(cfg_row(1'b0, 4'd0, 4'h1));
    // drop oldest on overflow
    plan.push_back(known_row(CMD_PUBLISH, 8'h00, 11'd0, 32'd14, 1'b0, 8'h00, 11'd4));
    plan.push_back(cmd_row(CMD_POP, 8'h00, 11'd0, 32'd0));
    plan.push_back(known_row(CMD_CLEAR, 8'h00, 11'd0, 32'd0, 1'b1, 8'h00, 11'd0));
    plan.push_back(known_row(CMD_SPARE_HI, 8'hFF, 11'd5, 32'd9, 1'b0, 8'h00, 11'd0));
    plan.push_back(known_row(CMD_COMMIT_PRODUCED, 8'h00, 11'd2047, 32'd0, 1'b0, 8'h00, 11'd0));
    // oversized log2 falls back to the full store
    plan.push_back(cfg_row(1'b1, 4'd15, 4'hF));
    plan.push_back(known_row(CMD_PUSH, 8'h3C, 11'd0, 32'd0, 1'b1, 8'h00, 11'd1));
    plan.push_back(known_row(CMD_COMMIT_PRODUCED, 8'h00, 11'd1023, 32'd0, 1'b1, 8'h00, 11'd1024));
    plan.push_back(known_row(CMD_PUBLISH, 8'h00, 11'd0, 32'h8000_03FF, 1'b0, 8'h00, 11'd1024));
    plan.push_back(known_row(CMD_COMMIT_CONSUMED, 8'h00, 11'd1024, 32'd0, 1'b1, 8'h00, 11'd0));
    plan.push_back(cfg_row(1'b1, 4'd0, 4'h0));
    plan.push_back(known_row(CMD_PUSH, 8'h81, 11'd0, 32'd0, 1'b1, 8'h00, 11'd1));
    plan.push_back(known_row(CMD_PUSH, 8'h7E, 11'd0, 32'd0, 1'b0, 8'h00, 11'd1));
    plan.push_back(known_row(CMD_POP, 8'h00, 11'd0, 32'd0, 1'b1, 8'h81, 11'd0));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        set_ring(plan[i].set_lg, plan[i].lg, plan[i].keep);
      end else begin
        run_item(plan[i].op, plan[i].b, plan[i].n, plan[i].np, plan[i].typed,
                 plan[i].t_ok, plan[i].t_byte, plan[i].t_occ);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) lg = 4'd10;
      else if (ph == 1) lg = 4'd0;
      else if (ph == 2) lg = 4'd15;
      else if ($urandom_range(9) < 7) lg = LG_W'($urandom_range(1, 5));
      else lg = LG_W'($urandom_range(6, 15));
      set_ring(ph % 4 != 3, lg, 4'($urandom_range(15)));
      calm = (ph == 6);
      tilt = $urandom_range(25, 50);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 4 && k == 10) hold_asks++;
        sz = ring_bytes();
        fill = prod_pos - cons_pos;
        pick = $urandom_range(99);
        b = BYTE_W'($urandom_range(255));
        n = ($urandom_range(4) == 0) ? FILL_W'($urandom_range(2047))
                                     : FILL_W'($urandom_range(sz + 1));
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5: np = prod_pos + $urandom_range(2 * sz + 2);
          6, 7: np = prod_pos - $urandom_range(sz);
          8: np = $urandom();
          default: np = prod_pos + 32'h7FFF_FFF0 + $urandom_range(31);
        endcase
        if (pick < tilt) op = CMD_PUSH;
        else if (pick < 55) op = CMD_POP;
        else if (pick < 66) op = CMD_COMMIT_PRODUCED;
        else if (pick < 77) op = CMD_COMMIT_CONSUMED;
        else if (pick < 92) op = CMD_PUBLISH;
        else if (pick < 95) op = CMD_CLEAR;
        else op = pick[0] ? CMD_SPARE_HI : CMD_SPARE_LO;
        // never read a store entry that no push has written
        if (op == CMD_POP && fill != 0 && !filled[cons_pos & (sz - 1)]) op = CMD_PUSH;
        run_item(op, b, n, np, 1'b0, 1'b0, 8'h00, 11'd0);
      end
    end

    in_valid <= 1'b0;
    calm = 1'b0;
    wait_left = 5000;
    while (status_due.size() != 0 && wait_left > 0) begin
      @(posedge clk);
      wait_left--;
    end
    repeat (8) @(posedge clk);
    if (status_due.size() != 0)
      flag_mismatch("results never returned", status_due.size(), '0);

    $display("%0d commands (%0d results checked), %0d register writes, ring sizes 1 to 1024",
             items_sent, statuses_checked, cfg_writes);
    $display("%0d pushes into a full ring, %0d overflowing publishes, %0d mismatches",
             full_pushes, spill_publishes, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- byte_ring_fifo_with_watermark.f -----
rtl/brf_pkg.sv
rtl/brf_store.sv
rtl/brf_core.sv
rtl/byte_ring_fifo_with_watermark.sv
verif/tb_byte_ring_fifo_with_watermark.sv
